FILE: hw/rtl/ecpr_pkg.sv
// Shared constants, types and helper functions for the enhanced clock page replacer.
// No dependencies; every other file of the block imports this package.
package ecpr_pkg;

    localparam int FRAMES    = 8;
    localparam int PAGE_BITS = 20;

    localparam int IO_PAGE_W = 20;
    localparam int IO_FRAME_W = 6;
    localparam int CFG_W     = 7;
    localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W     = $clog2(FRAMES + 1);

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [PAGE_BITS-1:0] t_page;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_SCAN,
        OP_HIT,
        OP_FILL,
        OP_SWEEP_INIT,
        OP_CLEAN_STEP,
        OP_DIRTY_STEP,
        OP_EVICT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic cur_hit;
        logic cur_free;
        logic free_seen;
        logic last_scan;
        logic last_sweep;
        logic cur_use;
        logic cur_dirty;
        logic out_free;
    } t_dp_sts;

    function automatic t_page to_page(input logic [IO_PAGE_W-1:0] x);
        logic [63:0] w;
        w = 64'(x);
        return w[PAGE_BITS-1:0];
    endfunction

    function automatic logic [IO_PAGE_W-1:0] from_page(input t_page p);
        logic [63:0] w;
        w = 64'(p);
        return w[IO_PAGE_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/ecpr_if.sv
// Valid/ready channel interfaces for page references and replacement results.
// Depends on ecpr_pkg for the field widths.
interface ecpr_req_if;
    import ecpr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [IO_PAGE_W-1:0] page_number;
    logic                 is_write;

    modport source (output valid, output page_number, output is_write, input ready);
    modport sink   (input valid, input page_number, input is_write, output ready);
endinterface

interface ecpr_rsp_if;
    import ecpr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  fault;
    logic [IO_FRAME_W-1:0] frame_index;
    logic                  evicted_valid;
    logic [IO_PAGE_W-1:0]  evicted_page;
    logic                  evicted_dirty;

    modport source (output valid, output fault, output frame_index, output evicted_valid,
                    output evicted_page, output evicted_dirty, input ready);
    modport sink   (input valid, input fault, input frame_index, input evicted_valid,
                    input evicted_page, input evicted_dirty, output ready);
endinterface

FILE: hw/rtl/ecpr_ctrl.sv
// Control state machine of the page replacer: lookup scan and the clean and dirty clock sweeps.
// Depends on ecpr_pkg; drives ecpr_datapath through command and status structs.
module ecpr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ecpr_pkg::t_dp_sts i_sts,
    output ecpr_pkg::t_dp_cmd o_cmd
);
    import ecpr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_CLEAN,
        S_DIRTY
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;
    t_op    op;

    always_comb begin
        n_state = r_state;
        op      = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    op      = OP_START;
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (i_sts.cur_hit) begin
                    if (i_sts.out_free) begin
                        op      = OP_HIT;
                        n_state = S_IDLE;
                    end
                end else if (i_sts.last_scan) begin
                    if (i_sts.free_seen || i_sts.cur_free) begin
                        if (i_sts.out_free) begin
                            op      = OP_FILL;
                            n_state = S_IDLE;
                        end
                    end else begin
                        op      = OP_SWEEP_INIT;
                        n_state = S_CLEAN;
                    end
                end else begin
                    op = OP_SCAN;
                end
            end
            S_CLEAN: begin
                if (!i_sts.cur_use && !i_sts.cur_dirty) begin
                    if (i_sts.out_free) begin
                        op      = OP_EVICT;
                        n_state = S_IDLE;
                    end
                end else begin
                    op = OP_CLEAN_STEP;
                    if (i_sts.last_sweep) begin
                        n_state = S_DIRTY;
                    end
                end
            end
            S_DIRTY: begin
                if (!i_sts.cur_use && i_sts.cur_dirty) begin
                    if (i_sts.out_free) begin
                        op      = OP_EVICT;
                        n_state = S_IDLE;
                    end
                end else begin
                    op = OP_DIRTY_STEP;
                    if (i_sts.last_sweep) begin
                        n_state = S_CLEAN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;
    assign o_cmd.op   = op;

endmodule

FILE: hw/rtl/ecpr_datapath.sv
// Frame table, clock hand, scan pointer and result register of the page replacer.
// Depends on ecpr_pkg; executes the commands issued by ecpr_ctrl.
module ecpr_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ecpr_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic [ecpr_pkg::IO_PAGE_W-1:0] i_page_number,
    input  logic                           i_is_write,
    input  ecpr_pkg::t_dp_cmd              i_cmd,
    output ecpr_pkg::t_dp_sts              o_sts,
    input  logic                           i_rsp_ready,
    output logic                           o_rsp_valid,
    output logic                           o_fault,
    output logic [ecpr_pkg::IO_FRAME_W-1:0] o_frame_index,
    output logic                           o_evicted_valid,
    output logic [ecpr_pkg::IO_PAGE_W-1:0] o_evicted_page,
    output logic                           o_evicted_dirty
);
    import ecpr_pkg::*;

    logic [CFG_W-1:0]  r_cfg;
    t_page             r_page [FRAMES];
    logic [FRAMES-1:0] r_valid;
    logic [FRAMES-1:0] r_use;
    logic [FRAMES-1:0] r_dirty;
    t_idx              r_hand;
    t_idx              r_ptr;
    t_idx              r_cnt;
    logic              r_free_seen;
    t_idx              r_free_idx;
    t_page             r_req_page;
    logic              r_req_wr;

    logic              r_out_valid;
    logic              r_fault;
    t_idx              r_frame;
    logic              r_ev_valid;
    t_page             r_ev_page;
    logic              r_ev_dirty;

    t_cnt  m;
    t_idx  m_last;
    t_idx  next_ptr;
    t_idx  fill_idx;
    t_idx  tgt_idx;
    logic  commit;
    logic  out_free;

    always_comb begin
        if (r_cfg == '0) begin
            m = CNT_W'(1);
        end else if (r_cfg > CFG_W'(FRAMES)) begin
            m = CNT_W'(FRAMES);
        end else begin
            m = CNT_W'(r_cfg);
        end
    end

    assign m_last   = IDX_W'(m - CNT_W'(1));
    assign next_ptr = ((CNT_W'(r_ptr) + CNT_W'(1)) >= m) ? '0 : IDX_W'(r_ptr + IDX_W'(1));
    assign fill_idx = r_free_seen ? r_free_idx : r_ptr;
    assign tgt_idx  = (i_cmd.op == OP_FILL) ? fill_idx : r_ptr;
    assign out_free = !r_out_valid || i_rsp_ready;
    assign commit   = (i_cmd.op == OP_HIT) || (i_cmd.op == OP_FILL) || (i_cmd.op == OP_EVICT);

    assign o_sts.cur_hit    = r_valid[r_ptr] && (r_page[r_ptr] == r_req_page);
    assign o_sts.cur_free   = !r_valid[r_ptr];
    assign o_sts.free_seen  = r_free_seen;
    assign o_sts.last_scan  = (r_ptr == m_last);
    assign o_sts.last_sweep = (r_cnt == m_last);
    assign o_sts.cur_use    = r_use[r_ptr];
    assign o_sts.cur_dirty  = r_dirty[r_ptr];
    assign o_sts.out_free   = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= CFG_RESET;
            r_valid     <= '0;
            r_use       <= '0;
            r_dirty     <= '0;
            r_hand      <= '0;
            r_ptr       <= '0;
            r_cnt       <= '0;
            r_free_seen <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_START: begin
                    r_ptr       <= '0;
                    r_free_seen <= 1'b0;
                end
                OP_SCAN: begin
                    if (!r_valid[r_ptr]) begin
                        r_free_seen <= 1'b1;
                    end
                    r_ptr <= IDX_W'(r_ptr + IDX_W'(1));
                end
                OP_HIT: begin
                    r_use[r_ptr]   <= 1'b1;
                    r_dirty[r_ptr] <= r_dirty[r_ptr] | r_req_wr;
                end
                OP_FILL: begin
                    r_valid[fill_idx] <= 1'b1;
                    r_use[fill_idx]   <= 1'b1;
                    r_dirty[fill_idx] <= r_req_wr;
                end
                OP_SWEEP_INIT: begin
                    r_ptr <= (CNT_W'(r_hand) >= m) ? '0 : r_hand;
                    r_cnt <= '0;
                end
                OP_CLEAN_STEP: begin
                    r_ptr <= next_ptr;
                    r_cnt <= (r_cnt == m_last) ? '0 : IDX_W'(r_cnt + IDX_W'(1));
                end
                OP_DIRTY_STEP: begin
                    r_use[r_ptr] <= 1'b0;
                    r_ptr        <= next_ptr;
                    r_cnt        <= (r_cnt == m_last) ? '0 : IDX_W'(r_cnt + IDX_W'(1));
                end
                OP_EVICT: begin
                    r_use[r_ptr]   <= 1'b1;
                    r_dirty[r_ptr] <= r_req_wr;
                    r_hand         <= next_ptr;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_START) begin
            r_req_page <= to_page(i_page_number);
            r_req_wr   <= i_is_write;
        end
        if ((i_cmd.op == OP_SCAN) && !r_valid[r_ptr] && !r_free_seen) begin
            r_free_idx <= r_ptr;
        end
        if ((i_cmd.op == OP_FILL) || (i_cmd.op == OP_EVICT)) begin
            r_page[tgt_idx] <= r_req_page;
        end
        if (commit) begin
            r_fault    <= (i_cmd.op != OP_HIT);
            r_frame    <= tgt_idx;
            r_ev_valid <= (i_cmd.op == OP_EVICT);
            r_ev_page  <= (i_cmd.op == OP_EVICT) ? r_page[r_ptr] : '0;
            r_ev_dirty <= (i_cmd.op == OP_EVICT) ? r_dirty[r_ptr] : 1'b0;
        end
    end

    assign o_rsp_valid     = r_out_valid;
    assign o_fault         = r_fault;
    assign o_frame_index   = IO_FRAME_W'(r_frame);
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = from_page(r_ev_page);
    assign o_evicted_dirty = r_ev_dirty;

    a_commit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |-> out_free)
        else $error("Result register overwritten before it was taken.");

    a_frame_valid_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_valid[r_frame])
        else $error("Reported frame is not valid after the transaction.");

    a_hit_has_no_eviction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_fault) |-> (!r_ev_valid && (r_ev_page == '0) && !r_ev_dirty))
        else $error("Hit result carries eviction data.");

    a_hand_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_hand) < CNT_W'(FRAMES))
        else $error("Clock hand beyond the frame table.");

endmodule

FILE: hw/rtl/enhanced_clock_page_replacer.sv
// Top level of the enhanced second-chance clock page replacer.
// Depends on ecpr_pkg, ecpr_if, ecpr_ctrl and ecpr_datapath.
//
// Usage: page references enter on i_req (page_number, is_write) and each
// produces exactly one result transaction on o_rsp (fault, frame_index,
// evicted_valid, evicted_page, evicted_dirty). The user must write the frame
// count register through i_cfg_we and i_cfg_wdata only while the block is
// idle; the block itself does not enforce this. A reference is looked up
// one frame per cycle, starting at frame 0, up to a hit or the last frame in
// use; a miss fills a free frame seen in the scan, else a replacement sweeps
// the frames from the clock hand for a frame to evict. The next reference
// is accepted in the cycle after the commit.
// One reference is processed at a time.
// Reset clears all valid, use and dirty bits, the clock hand and the result
// valid flag, and sets the frame count to 8. When the receiver stalls, the
// result is held, and a following reference is worked on but not committed
// until the output register is free.
module enhanced_clock_page_replacer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ecpr_pkg::CFG_W-1:0]   i_cfg_wdata,
    ecpr_req_if.sink                     i_req,
    ecpr_rsp_if.source                   o_rsp
);
    import ecpr_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    ecpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ecpr_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_page_number   (i_req.page_number),
        .i_is_write      (i_req.is_write),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_rsp_ready     (o_rsp.ready),
        .o_rsp_valid     (o_rsp.valid),
        .o_fault         (o_rsp.fault),
        .o_frame_index   (o_rsp.frame_index),
        .o_evicted_valid (o_rsp.evicted_valid),
        .o_evicted_page  (o_rsp.evicted_page),
        .o_evicted_dirty (o_rsp.evicted_dirty)
    );

    assign i_req.ready = in_ready;

endmodule
